/* sv/osr_pkg.sv */
`timescale 1ns / 1ps
package osr_pkg;

    // command codes carried in the action field
    typedef enum logic [1:0] {
        ACT_EDGE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TEST  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_RCLR,
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_ROW_CHK,
        S_ROW_LD,
        S_PIX_CHK,
        S_PIX_UPD,
        S_RESULT
    } state_t;

    // internal coordinate type, wide enough for clamped bounds
    typedef logic signed [17:0] coord_t;

    localparam logic [15:0]        DEPTH_FAR  = 16'hFFFF;
    localparam logic signed [15:0] LEFT_INIT  = 16'sh7FFF;
    localparam logic signed [15:0] RIGHT_INIT = 16'sh8000;

    // line stepper control and status
    typedef struct packed {
        logic load;
        logic step;
    } bres_ctl_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } bres_stat_t;

endpackage

/* sv/osr_in_if.sv */
`timescale 1ns / 1ps
interface osr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [15:0]        depth;

    modport source (output valid, action, start_x, start_y, end_x, end_y, depth,
                    input ready);
    modport sink (input valid, action, start_x, start_y, end_x, end_y, depth,
                  output ready);
endinterface

/* sv/osr_out_if.sv */
`timescale 1ns / 1ps
interface osr_out_if;
    logic valid;
    logic ready;
    logic occluded;

    modport source (output valid, occluded, input ready);
    modport sink (input valid, occluded, output ready);
endinterface

/* sv/osr_ram.sv */
`timescale 1ns / 1ps
module osr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/osr_bres.sv */
`timescale 1ns / 1ps
module osr_bres
    import osr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bres_ctl_t          ctl,
    input  logic signed [15:0] x0,
    input  logic signed [15:0] y0,
    input  logic signed [15:0] x1,
    input  logic signed [15:0] y1,
    output bres_stat_t         stat
);

    logic signed [15:0] x_reg, y_reg, x1_reg, y1_reg;
    logic signed [15:0] x_next, y_next;
    logic [16:0]        dx_reg, dy_reg, dx_load, dy_load;
    logic               sx_neg_reg, sy_neg_reg;
    logic signed [18:0] err_reg, err_next;
    logic signed [19:0] e2;
    logic signed [16:0] x0_e, x1_e, y0_e, y1_e;

    // absolute deltas at load
    assign x0_e = 17'(x0);
    assign x1_e = 17'(x1);
    assign y0_e = 17'(y0);
    assign y1_e = 17'(y1);
    assign dx_load = (x1_e > x0_e) ? 17'(x1_e - x0_e) : 17'(x0_e - x1_e);
    assign dy_load = (y1_e > y0_e) ? 17'(y1_e - y0_e) : 17'(y0_e - y1_e);

    // one bresenham step
    always_comb
    begin
        e2       = 20'(err_reg) <<< 1;
        err_next = err_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        if (e2 > -$signed({3'b000, dy_reg}))
        begin
            err_next = err_next - $signed({2'b00, dy_reg});
            x_next   = sx_neg_reg ? x_reg - 16'sd1 : x_reg + 16'sd1;
        end
        if (e2 < $signed({3'b000, dx_reg}))
        begin
            err_next = err_next + $signed({2'b00, dx_reg});
            y_next   = sy_neg_reg ? y_reg - 16'sd1 : y_reg + 16'sd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            x1_reg     <= '0;
            y1_reg     <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            sx_neg_reg <= 1'b0;
            sy_neg_reg <= 1'b0;
            err_reg    <= '0;
        end
        else if (ctl.load)
        begin
            x_reg      <= x0;
            y_reg      <= y0;
            x1_reg     <= x1;
            y1_reg     <= y1;
            dx_reg     <= dx_load;
            dy_reg     <= dy_load;
            sx_neg_reg <= !(x0 < x1);
            sy_neg_reg <= !(y0 < y1);
            err_reg    <= $signed({2'b00, dx_load}) - $signed({2'b00, dy_load});
        end
        else if (ctl.step)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            err_reg <= err_next;
        end
    end

    assign stat.x    = x_reg;
    assign stat.y    = y_reg;
    assign stat.done = (x_reg == x1_reg) && (y_reg == y1_reg);

endmodule

/* sv/occlusion_span_raster.sv */
`timescale 1ns / 1ps
// Depth map occlusion rasterizer. Edge transactions are walked one pixel at a time by a
// line stepper, each on-map pixel taking a read-modify-write of the row span memory.
// Write and test transactions sweep the span row by row, reading the depth memory for
// each covered cell and, for a write, updating it; then a pass clears the row spans and
// a test hands over its result. After reset the block clears the depth map and row
// spans before it takes its first transaction. A test gives one result transaction;
// edge and write give none. The block takes a new transaction while an earlier result
// is still waiting to be taken.
module occlusion_span_raster
    import osr_pkg::*;
#(
    parameter int MAP_WIDTH  = 256,
    parameter int MAP_HEIGHT = 256
) (
    input  logic clk,
    input  logic rst_n,
    osr_in_if.sink    in_ch,
    osr_out_if.source out_ch
);

    localparam int XA = $clog2(MAP_WIDTH);
    localparam int YA = $clog2(MAP_HEIGHT);
    localparam int DA = $clog2(MAP_WIDTH * MAP_HEIGHT);
    localparam logic [DA-1:0] DEPTH_LAST = DA'(MAP_WIDTH * MAP_HEIGHT - 1);
    localparam logic [YA-1:0] ROW_LAST   = YA'(MAP_HEIGHT - 1);
    localparam coord_t W_C = coord_t'(MAP_WIDTH);
    localparam coord_t H_C = coord_t'(MAP_HEIGHT);

    state_t state_reg, state_next;
    action_t cmd_reg;
    logic [15:0] z_reg;
    coord_t y_reg, yhi_reg, x_reg, xhi_reg;
    logic [DA-1:0] base_reg, clr_reg;
    logic signed [15:0] top_reg, bot_reg;
    logic occ_reg, out_valid_reg, occluded_reg;

    bres_ctl_t  bctl;
    bres_stat_t bstat;

    logic          row_we;
    logic [YA-1:0] row_waddr, row_raddr;
    logic [31:0]   row_wdata, row_rdata;
    logic          dep_we;
    logic [DA-1:0] dep_waddr, dep_addr;
    logic [15:0]   dep_wdata, dep_rdata;

    logic   accept, skip, on_map, result_free;
    coord_t sx0, sy0, sx1, sy1, ey;
    coord_t ylo_c, yhi_c, xlo_c, xhi_c, rl, rr;
    logic signed [15:0] rl16, rr16, new_left, new_right;
    logic signed [15:0] ymin_in, ymax_in;

    assign accept = in_ch.valid && in_ch.ready;

    // edge endpoints and side rejection
    assign sx0 = coord_t'(in_ch.start_x);
    assign sy0 = coord_t'(in_ch.start_y);
    assign sx1 = coord_t'(in_ch.end_x);
    assign sy1 = coord_t'(in_ch.end_y);
    assign skip = (sx0 < 0 && sx1 < 0) || (sy0 < 0 && sy1 < 0) ||
                  (sx0 >= W_C && sx1 >= W_C) || (sy0 >= H_C && sy1 >= H_C);
    assign ymin_in = (in_ch.start_y < in_ch.end_y) ? in_ch.start_y : in_ch.end_y;
    assign ymax_in = (in_ch.start_y > in_ch.end_y) ? in_ch.start_y : in_ch.end_y;

    // current walked pixel
    assign ey = coord_t'(bstat.y);
    assign on_map = (ey >= 0) && (ey < H_C);

    // row span update for the walked pixel
    assign rl16 = row_rdata[31:16];
    assign rr16 = row_rdata[15:0];
    assign new_left  = (bstat.x < rl16) ? bstat.x : rl16;
    assign new_right = (bstat.x > rr16) ? bstat.x : rr16;

    // row bounds of the command sweep
    always_comb
    begin
        if (in_ch.action == ACT_WRITE)
        begin
            ylo_c = coord_t'(top_reg) + coord_t'(1);
            yhi_c = coord_t'(bot_reg);
        end
        else
        begin
            ylo_c = coord_t'(top_reg);
            yhi_c = coord_t'(bot_reg) + coord_t'(1);
        end
        if (ylo_c < 0)
        begin
            ylo_c = '0;
        end
        if (yhi_c > H_C)
        begin
            yhi_c = H_C;
        end
    end

    // column bounds of the current row
    assign rl = coord_t'(rl16);
    assign rr = coord_t'(rr16);
    always_comb
    begin
        if (cmd_reg == ACT_WRITE)
        begin
            xlo_c = rl + coord_t'(1);
            xhi_c = rr;
        end
        else
        begin
            xlo_c = rl;
            xhi_c = rr + coord_t'(1);
        end
        if (xlo_c < 0)
        begin
            xlo_c = '0;
        end
        if (xhi_c > W_C)
        begin
            xhi_c = W_C;
        end
    end

    assign result_free = !out_valid_reg || out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_reg == DEPTH_LAST)
                begin
                    state_next = S_RCLR;
                end
            end
            S_RCLR:
            begin
                if (clr_reg[YA-1:0] == ROW_LAST)
                begin
                    state_next = (cmd_reg == ACT_TEST) ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(in_ch.action))
                        ACT_EDGE:  state_next = skip ? S_IDLE : S_EDGE_RD;
                        ACT_WRITE: state_next = S_ROW_CHK;
                        ACT_TEST:  state_next = S_ROW_CHK;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_EDGE_RD:
            begin
                if (on_map)
                begin
                    state_next = S_EDGE_WR;
                end
                else if (bstat.done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EDGE_WR: state_next = bstat.done ? S_IDLE : S_EDGE_RD;
            S_ROW_CHK: state_next = (y_reg < yhi_reg) ? S_ROW_LD : S_RCLR;
            S_ROW_LD:  state_next = S_PIX_CHK;
            S_PIX_CHK: state_next = (x_reg < xhi_reg) ? S_PIX_UPD : S_ROW_CHK;
            S_PIX_UPD: state_next = S_PIX_CHK;
            S_RESULT:
            begin
                if (result_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ch.ready = (state_reg == S_IDLE);
        bctl.load   = 1'b0;
        bctl.step   = 1'b0;
        row_we      = 1'b0;
        row_waddr   = ey[YA-1:0];
        row_wdata   = {new_left, new_right};
        row_raddr   = ey[YA-1:0];
        dep_we      = 1'b0;
        dep_waddr   = dep_addr;
        dep_wdata   = z_reg;
        case (state_reg)
            S_INIT:
            begin
                dep_we    = 1'b1;
                dep_waddr = clr_reg;
                dep_wdata = DEPTH_FAR;
            end
            S_RCLR:
            begin
                row_we    = 1'b1;
                row_waddr = clr_reg[YA-1:0];
                row_wdata = {LEFT_INIT, RIGHT_INIT};
            end
            S_IDLE:
            begin
                bctl.load = accept && (in_ch.action == ACT_EDGE) && !skip;
            end
            S_EDGE_RD:
            begin
                bctl.step = !on_map && !bstat.done;
            end
            S_EDGE_WR:
            begin
                row_we    = 1'b1;
                bctl.step = !bstat.done;
            end
            S_ROW_CHK:
            begin
                row_raddr = y_reg[YA-1:0];
            end
            S_PIX_UPD:
            begin
                dep_we = (cmd_reg == ACT_WRITE) && (z_reg < dep_rdata);
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    assign dep_addr = base_reg + DA'(x_reg[XA-1:0]);

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            clr_reg   <= '0;
            cmd_reg   <= ACT_EDGE;
            top_reg   <= LEFT_INIT;
            bot_reg   <= RIGHT_INIT;
            occ_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // clearing sweep counter
            if ((state_reg == S_INIT && clr_reg == DEPTH_LAST) ||
                (state_reg == S_RCLR && clr_reg[YA-1:0] == ROW_LAST))
            begin
                clr_reg <= '0;
            end
            else if (state_reg == S_INIT || state_reg == S_RCLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            // span row extent
            if (state_reg == S_RCLR && clr_reg[YA-1:0] == ROW_LAST)
            begin
                top_reg <= LEFT_INIT;
                bot_reg <= RIGHT_INIT;
            end
            else if (accept && in_ch.action == ACT_EDGE && !skip)
            begin
                top_reg <= (ymin_in < top_reg) ? ymin_in : top_reg;
                bot_reg <= (ymax_in > bot_reg) ? ymax_in : bot_reg;
            end
            // command latch
            if (accept && (in_ch.action == ACT_WRITE || in_ch.action == ACT_TEST))
            begin
                cmd_reg <= action_t'(in_ch.action);
                occ_reg <= 1'b1;
            end
            else if (state_reg == S_PIX_UPD && cmd_reg == ACT_TEST && z_reg < dep_rdata)
            begin
                occ_reg <= 1'b0;
            end
        end
    end

    // sweep datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            z_reg   <= in_ch.depth;
            y_reg   <= ylo_c;
            yhi_reg <= yhi_c;
        end
        case (state_reg)
            S_ROW_LD:
            begin
                x_reg    <= xlo_c;
                xhi_reg  <= xhi_c;
                base_reg <= DA'(y_reg[YA-1:0] * MAP_WIDTH);
            end
            S_PIX_CHK:
            begin
                if (!(x_reg < xhi_reg))
                begin
                    y_reg <= y_reg + coord_t'(1);
                end
            end
            S_PIX_UPD:
            begin
                x_reg <= x_reg + coord_t'(1);
            end
            default:
            begin
                base_reg <= base_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            occluded_reg  <= 1'b0;
        end
        else if (state_reg == S_RESULT && result_free)
        begin
            out_valid_reg <= 1'b1;
            occluded_reg  <= occ_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.occluded = occluded_reg;

    osr_bres u_bres (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bctl),
        .x0    (in_ch.start_x),
        .y0    (in_ch.start_y),
        .x1    (in_ch.end_x),
        .y1    (in_ch.end_y),
        .stat  (bstat)
    );

    osr_ram #(.WIDTH(32), .DEPTH(MAP_HEIGHT)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    osr_ram #(.WIDTH(16), .DEPTH(MAP_WIDTH * MAP_HEIGHT)) u_depth_ram (
        .clk   (clk),
        .we    (dep_we),
        .waddr (dep_waddr),
        .wdata (dep_wdata),
        .raddr (dep_addr),
        .rdata (dep_rdata)
    );

endmodule
